// ===== sv/best_fit_extent_allocator_assert.svh =====
// Assertion macros used by the extent allocator checker.
`ifndef BEST_FIT_EXTENT_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_EXTENT_ALLOCATOR_ASSERT_SVH

// Property checked at each rising clock edge, masked while reset is high.
`define BFEA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Implication checked at each rising clock edge, masked while reset is high.
`define BFEA_ASSERT_IMP(label, ante, cons, msg) \
   `BFEA_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== sv/bfea_pkg.sv =====
// Shared types, constants and status codes of the extent allocator.
package bfea_pkg;

   localparam int unsigned FREE_ENTRIES_DEF = 64;
   localparam int unsigned USED_ENTRIES_DEF = 64;
   localparam logic [15:0] POOL_RESET       = 16'd10000;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_FIT  = 2'd1;
   localparam logic [1:0] ST_NO_ADDR = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   typedef struct packed {
      logic [15:0] start;
      logic [15:0] length;
   } extent_type;

   localparam int unsigned EXTENT_BITS = $bits(extent_type);

endpackage

// ===== sv/bfea_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bfea_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word; read one word, hold it while no read is issued
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/best_fit_extent_allocator.sv =====
// Best-fit extent allocator with coalescing on free, tables held in RAM.
//
// An item is accepted when start is high and busy is low; its result shows on
// the rsp_ ports for one cycle with rsp_valid, and must be taken then. The
// result cycle is the first cycle with busy low again, so the next word may be
// accepted at the edge that ends it. Each table is one RAM, read one entry at a
// time: a scan step issues the read, then checks the entry. An allocate scans
// every free entry, then writes back, with a further step to move the last free
// entry when it empties its free extent. A free scans the used table to find its
// entry, then makes a merge pass over the free table and writes back; absorbed
// neighbors do not lengthen the pass. A free of an unknown address scans every
// used entry, and one refused for a full free table makes both passes. After
// reset the block is busy while it writes the initial free extent.
module best_fit_extent_allocator #(
   parameter int unsigned FREE_ENTRIES = bfea_pkg::FREE_ENTRIES_DEF,
   parameter int unsigned USED_ENTRIES = bfea_pkg::USED_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [15:0] req_request_size,
   input  logic [15:0] req_address,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_block_start,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import bfea_pkg::*;

   localparam int unsigned FA = $clog2(FREE_ENTRIES);
   localparam int unsigned FC = $clog2(FREE_ENTRIES + 1);
   localparam int unsigned UA = (USED_ENTRIES > 1) ? $clog2(USED_ENTRIES) : 1;
   localparam int unsigned UC = $clog2(USED_ENTRIES + 1);
   localparam logic [FC-1:0] FREE_CNT = FC'(FREE_ENTRIES);
   localparam logic [UC-1:0] USED_CNT = UC'(USED_ENTRIES);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_INIT  = 4'd1;
   localparam logic [3:0] S_A_RD  = 4'd2;
   localparam logic [3:0] S_A_CHK = 4'd3;
   localparam logic [3:0] S_A_DEC = 4'd4;
   localparam logic [3:0] S_A_MV  = 4'd5;
   localparam logic [3:0] S_U_RD  = 4'd6;
   localparam logic [3:0] S_U_CHK = 4'd7;
   localparam logic [3:0] S_F_RD  = 4'd8;
   localparam logic [3:0] S_F_CHK = 4'd9;
   localparam logic [3:0] S_F_MV  = 4'd10;
   localparam logic [3:0] S_F_APP = 4'd11;
   localparam logic [3:0] S_U_MV  = 4'd12;

   logic [3:0]    state_ff, state_in;
   logic [15:0]   pool_ff, pool_in;
   logic [FC-1:0] free_count_ff, free_count_in;
   logic [UC-1:0] used_count_ff, used_count_in;
   logic [15:0]   req_ff, req_in;
   logic [15:0]   addr_ff, addr_in;
   logic [FC-1:0] fi_ff, fi_in;
   logic [UC-1:0] ui_ff, ui_in;
   logic          best_found_ff, best_found_in;
   logic [FA-1:0] best_idx_ff, best_idx_in;
   logic [15:0]   best_start_ff, best_start_in;
   logic [15:0]   best_len_ff, best_len_in;
   logic [15:0]   m_start_ff, m_start_in;
   logic [16:0]   m_len_ff, m_len_in;
   logic [FC-1:0] n_ff, n_in;
   logic [UA-1:0] uidx_ff, uidx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [15:0]   rsp_block_ff, rsp_block_in;

   logic                   f_we, f_re;
   logic [FA-1:0]          f_waddr, f_raddr;
   logic [EXTENT_BITS-1:0] f_wdata, f_rdata;
   logic                   u_we, u_re;
   logic [UA-1:0]          u_waddr, u_raddr;
   logic [EXTENT_BITS-1:0] u_wdata, u_rdata;

   bfea_ram #(.WIDTH(EXTENT_BITS), .DEPTH(FREE_ENTRIES), .AW(FA)) u_free_ram (
      .clock   (clock),
      .wr_en   (f_we),
      .wr_addr (f_waddr),
      .wr_data (f_wdata),
      .rd_en   (f_re),
      .rd_addr (f_raddr),
      .rd_data (f_rdata)
   );

   bfea_ram #(.WIDTH(EXTENT_BITS), .DEPTH(USED_ENTRIES), .AW(UA)) u_used_ram (
      .clock   (clock),
      .wr_en   (u_we),
      .wr_addr (u_waddr),
      .wr_data (u_wdata),
      .rd_en   (u_re),
      .rd_addr (u_raddr),
      .rd_data (u_rdata)
   );

   // Sequence table reads, compares and write-backs
   always_comb begin
      extent_type    fe;
      extent_type    ue;
      extent_type    wr;
      logic [17:0]   m_end;
      logic [16:0]   f_end;
      logic          hit_after;
      logic          hit_before;
      logic [FC-1:0] n_dec;
      logic [FC-1:0] fc_dec;
      logic [UC-1:0] uc_dec;

      fe         = extent_type'(f_rdata);
      ue         = extent_type'(u_rdata);
      wr         = '0;
      m_end      = {2'b00, m_start_ff} + {1'b0, m_len_ff};
      f_end      = {1'b0, fe.start} + {1'b0, fe.length};
      hit_after  = ({2'b00, fe.start} == m_end);
      hit_before = !hit_after && (f_end == {1'b0, m_start_ff});
      n_dec      = n_ff - FC'(1);
      fc_dec     = free_count_ff - FC'(1);
      uc_dec     = used_count_ff - UC'(1);

      state_in      = state_ff;
      pool_in       = pool_ff;
      free_count_in = free_count_ff;
      used_count_in = used_count_ff;
      req_in        = req_ff;
      addr_in       = addr_ff;
      fi_in         = fi_ff;
      ui_in         = ui_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_start_in = best_start_ff;
      best_len_in   = best_len_ff;
      m_start_in    = m_start_ff;
      m_len_in      = m_len_ff;
      n_in          = n_ff;
      uidx_in       = uidx_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_block_in  = rsp_block_ff;

      f_we    = 1'b0;
      f_waddr = '0;
      f_wdata = '0;
      f_re    = 1'b0;
      f_raddr = fi_ff[FA-1:0];
      u_we    = 1'b0;
      u_waddr = '0;
      u_wdata = '0;
      u_re    = 1'b0;
      u_raddr = ui_ff[UA-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in        = req_request_size;
               addr_in       = req_address;
               fi_in         = '0;
               ui_in         = '0;
               best_found_in = 1'b0;
               state_in      = req_mode ? S_U_RD : S_A_RD;
            end
         end
         S_INIT: begin
            // Write the single free extent of a fresh pool
            wr.start  = '0;
            wr.length = pool_ff;
            f_we      = 1'b1;
            f_waddr   = '0;
            f_wdata   = wr;
            state_in  = S_IDLE;
         end
         S_A_RD: begin
            if (fi_ff >= free_count_ff) begin
               state_in = S_A_DEC;
            end else begin
               f_re     = 1'b1;
               state_in = S_A_CHK;
            end
         end
         S_A_CHK: begin
            // Keep the smallest fitting extent, earliest on ties
            if (fe.length >= req_ff && (!best_found_ff || fe.length < best_len_ff)) begin
               best_found_in = 1'b1;
               best_idx_in   = fi_ff[FA-1:0];
               best_start_in = fe.start;
               best_len_in   = fe.length;
            end
            fi_in    = fi_ff + FC'(1);
            state_in = S_A_RD;
         end
         S_A_DEC: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            rsp_block_in = '0;
            if (req_ff == '0 || !best_found_ff) begin
               rsp_status_in = ST_NO_FIT;
            end else if (used_count_ff == USED_CNT) begin
               rsp_status_in = ST_FULL;
            end else begin
               // Record the used extent and carve the front of the free one
               wr.start      = best_start_ff;
               wr.length     = req_ff;
               u_we          = 1'b1;
               u_waddr       = used_count_ff[UA-1:0];
               u_wdata       = wr;
               used_count_in = used_count_ff + UC'(1);
               if (best_len_ff != req_ff) begin
                  wr.start      = best_start_ff + req_ff;
                  wr.length     = best_len_ff - req_ff;
                  f_we          = 1'b1;
                  f_waddr       = best_idx_ff;
                  f_wdata       = wr;
                  rsp_status_in = ST_OK;
                  rsp_block_in  = best_start_ff;
               end else begin
                  // Emptied: pull the last free entry into its slot
                  rsp_valid_in  = 1'b0;
                  free_count_in = fc_dec;
                  f_re          = 1'b1;
                  f_raddr       = fc_dec[FA-1:0];
                  state_in      = S_A_MV;
               end
            end
         end
         S_A_MV: begin
            f_we          = 1'b1;
            f_waddr       = best_idx_ff;
            f_wdata       = f_rdata;
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_block_in  = best_start_ff;
            state_in      = S_IDLE;
         end
         S_U_RD: begin
            if (ui_ff >= used_count_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NO_ADDR;
               rsp_block_in  = '0;
               state_in      = S_IDLE;
            end else begin
               u_re     = 1'b1;
               state_in = S_U_CHK;
            end
         end
         S_U_CHK: begin
            if (ue.start == addr_ff) begin
               uidx_in    = ui_ff[UA-1:0];
               m_start_in = ue.start;
               m_len_in   = {1'b0, ue.length};
               n_in       = free_count_ff;
               fi_in      = '0;
               state_in   = S_F_RD;
            end else begin
               ui_in    = ui_ff + UC'(1);
               state_in = S_U_RD;
            end
         end
         S_F_RD: begin
            if (fi_ff >= n_ff) begin
               state_in = S_F_APP;
            end else begin
               f_re     = 1'b1;
               state_in = S_F_CHK;
            end
         end
         S_F_CHK: begin
            // Absorb a neighbor that ends at our start or starts at our end
            if (hit_after || hit_before) begin
               if (hit_before) begin
                  m_start_in = fe.start;
               end
               m_len_in = m_len_ff + {1'b0, fe.length};
               n_in     = n_dec;
               if (fi_ff == n_dec) begin
                  state_in = S_F_RD;
               end else begin
                  f_re     = 1'b1;
                  f_raddr  = n_dec[FA-1:0];
                  state_in = S_F_MV;
               end
            end else begin
               fi_in    = fi_ff + FC'(1);
               state_in = S_F_RD;
            end
         end
         S_F_MV: begin
            // Move the last entry down, then recheck it in place
            f_we     = 1'b1;
            f_waddr  = fi_ff[FA-1:0];
            f_wdata  = f_rdata;
            state_in = S_F_CHK;
         end
         S_F_APP: begin
            if (n_ff >= FREE_CNT) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_FULL;
               rsp_block_in  = '0;
               state_in      = S_IDLE;
            end else begin
               wr.start      = m_start_ff;
               wr.length     = m_len_ff[15:0];
               f_we          = 1'b1;
               f_waddr       = n_ff[FA-1:0];
               f_wdata       = wr;
               free_count_in = n_ff + FC'(1);
               used_count_in = uc_dec;
               u_re          = 1'b1;
               u_raddr       = uc_dec[UA-1:0];
               state_in      = S_U_MV;
            end
         end
         S_U_MV: begin
            u_we          = 1'b1;
            u_waddr       = uidx_ff;
            u_wdata       = u_rdata;
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_block_in  = '0;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Reinitialize the pool on a register write
      if (csr_wr_en) begin
         pool_in       = csr_wr_data;
         free_count_in = (csr_wr_data == '0) ? FC'(0) : FC'(1);
         used_count_in = '0;
         wr.start      = '0;
         wr.length     = csr_wr_data;
         f_we          = 1'b1;
         f_waddr       = '0;
         f_wdata       = wr;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         pool_ff       <= POOL_RESET;
         free_count_ff <= FC'(1);
         used_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pool_ff       <= pool_in;
         free_count_ff <= free_count_in;
         used_count_ff <= used_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Working payload
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      addr_ff       <= addr_in;
      fi_ff         <= fi_in;
      ui_ff         <= ui_in;
      best_found_ff <= best_found_in;
      best_idx_ff   <= best_idx_in;
      best_start_ff <= best_start_in;
      best_len_ff   <= best_len_in;
      m_start_ff    <= m_start_in;
      m_len_ff      <= m_len_in;
      n_ff          <= n_in;
      uidx_ff       <= uidx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_block_ff  <= rsp_block_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_block_start = rsp_block_ff;

endmodule

// ===== sv/bfea_checker.sv =====
// Port-level checker of the extent allocator and its bind.
`include "best_fit_extent_allocator_assert.svh"

module bfea_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_block_start
);
   import bfea_pkg::*;

   // An accepted word keeps the block busy until its result
   `BFEA_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
   // A result comes out only as the block returns to idle
   `BFEA_ASSERT_IMP(a_rsp_idle, rsp_valid, !busy && $past(busy), "result without a busy phase")
   // One result per word
   `BFEA_ASSERT(a_rsp_single, rsp_valid |=> !rsp_valid, "result repeated")
   // Failed results carry no block start
   `BFEA_ASSERT_IMP(a_fail_zero, rsp_valid && rsp_status != ST_OK, rsp_block_start == '0,
                    "nonzero block start on failure")

endmodule

bind best_fit_extent_allocator bfea_checker u_bfea_checker (.*);
